// File: hw/rtl/ln1p_pkg.sv
// ----------------------------------------------------------------------------
// ln1p_pkg
// Shared constants and types for the ln(1+x) series evaluator.
// ----------------------------------------------------------------------------
package ln1p_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_TERMS_DEF = 4096;

  localparam int COUNT_W = 13;
  localparam int EPS_W   = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/ln1p_if.sv
// ----------------------------------------------------------------------------
// ln1p_if
// Valid/ready channels for the argument and result transactions.
// ----------------------------------------------------------------------------
interface ln1p_in_if #(
  parameter int FRAC_BITS = ln1p_pkg::FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface ln1p_out_if #(
  parameter int FRAC_BITS = ln1p_pkg::FRAC_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [FRAC_BITS+4:0]     log_sum;
  logic [ln1p_pkg::COUNT_W-1:0]    term_count;
  logic                            limit_hit;

  modport source (output valid, output log_sum, output term_count, output limit_hit,
                  input ready);
  modport sink   (input valid, input log_sum, input term_count, input limit_hit,
                  output ready);
endinterface

// File: hw/rtl/ln1p_div.sv
// ----------------------------------------------------------------------------
// ln1p_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ln1p_div #(
  parameter int NUM_W = ln1p_pkg::FRAC_BITS_DEF + 1,
  parameter int DEN_W = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [NUM_W-1:0]     quo,
  output ln1p_pkg::div_stat_t  stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      // remainder stays below den, so the low bits hold it
      rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hw/rtl/ln1p_taylor_series_top.sv
// Each series term runs the serial divider (start, FRAC_BITS + 1 quotient bit shifts, done),
//   then ST_ACC adds the term and ST_MUL forms the next power.
// One transaction at a time; arg.ready is high only when idle and the result has been taken,
//   so a new argument waits for the last result; at most MAX_TERMS terms per argument.
// Reset (rst, synchronous): sequencer idle, no result pending, epsilon = 66.
// ----------------------------------------------------------------------------
// ln1p_taylor_series_top
// ln(1+x) by its alternating Taylor series in fixed point, one term per pass
// through a shared serial divider and multiplier.
// ----------------------------------------------------------------------------
module ln1p_taylor_series_top #(
  parameter int MAX_TERMS = ln1p_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = ln1p_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ln1p_in_if.sink                      arg,
  ln1p_out_if.source                   res,
  input  logic                         wr_en,
  input  logic [ln1p_pkg::EPS_W-1:0]   wr_data
);

  localparam int XW   = FRAC_BITS + 2;
  localparam int PW_W = FRAC_BITS + 1;
  localparam int SW   = FRAC_BITS + 7;
  localparam int OW   = FRAC_BITS + 5;
  localparam int KW   = $clog2(MAX_TERMS + 1);
  localparam int SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int EW   = ln1p_pkg::EPS_W + FRAC_BITS;

  localparam logic signed [XW-1:0] X_HI = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [XW-1:0] X_LO = {2'b11, {(FRAC_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [SW-1:0] SUM_HI = {3'b000, {(FRAC_BITS+4){1'b1}}};
  localparam logic signed [SW-1:0] SUM_LO = {3'b111, {(FRAC_BITS+4){1'b0}}};
  localparam logic [2*PW_W-1:0]    HALF = (2*PW_W)'(1) << (FRAC_BITS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                   state;
  logic [ln1p_pkg::EPS_W-1:0]   epsilon;
  logic                         div_start;
  logic                         neg;
  logic [PW_W-1:0]              ax;
  logic [PW_W-1:0]              pw;
  logic [KW-1:0]                k;
  logic signed [SW-1:0]         sum;
  logic                         limit;
  logic [2*PW_W-1:0]            prod;

  logic signed [XW-1:0]         xc;
  logic [EW-1:0]                eps_wide;
  logic [FRAC_BITS-1:0]         eps_s;
  logic [PW_W-1:0]              term;
  logic [2*PW_W-1:0]            rounded;
  ln1p_pkg::div_stat_t          div_stat;

  ln1p_div #(
    .NUM_W (PW_W),
    .DEN_W (KW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pw),
    .den   (k),
    .quo   (term),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= ln1p_pkg::EPS_RESET;
    end else if (wr_en) begin
      epsilon <= wr_data;
    end
  end

  always_comb begin
    xc = arg.x_value;
    if (arg.x_value < X_LO) xc = X_LO;
    if (arg.x_value > X_HI) xc = X_HI;
  end

  assign eps_wide = (EW'(epsilon) << SHL) >> SHR;
  assign eps_s    = eps_wide[FRAC_BITS-1:0];
  assign rounded  = prod + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (arg.valid) begin
            state     <= ST_DIV;
            div_start <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_stat.done) state <= ST_ACC;
        end
        ST_ACC: begin
          if ((term <= PW_W'(eps_s)) || (k >= KW'(MAX_TERMS))) begin
            state <= ST_FIN;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state     <= ST_DIV;
          div_start <= 1'b1;
        end
        ST_FIN: begin
          if (res.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        neg   <= xc < 0;
        ax    <= (xc < 0) ? PW_W'(-xc) : PW_W'(xc);
        pw    <= (xc < 0) ? PW_W'(-xc) : PW_W'(xc);
        k     <= KW'(1);
        sum   <= '0;
        limit <= 1'b0;
      end
      ST_ACC: begin
        // odd terms add for x >= 0, everything subtracts for x < 0
        if (neg || !k[0]) sum <= sum - $signed(SW'(term));
        else              sum <= sum + $signed(SW'(term));
        limit <= (term > PW_W'(eps_s)) && (k >= KW'(MAX_TERMS));
        prod  <= pw * ax;
      end
      ST_MUL: begin
        pw <= rounded[FRAC_BITS +: PW_W];
        k  <= k + KW'(1);
      end
      default: begin
      end
    endcase
  end

  assign arg.ready = (state == ST_IDLE);

  assign res.valid      = (state == ST_FIN);
  assign res.log_sum    = (sum > SUM_HI) ? OW'(SUM_HI) :
                          (sum < SUM_LO) ? OW'(SUM_LO) : OW'(sum);
  assign res.term_count = ln1p_pkg::COUNT_W'(k);
  assign res.limit_hit  = limit;

  a_exclusive_sides: assert property (@(posedge clk) disable iff (rst)
    !(arg.ready && res.valid))
    else $error("input ready while a result is pending");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> ((k != '0) && (k <= KW'(MAX_TERMS))))
    else $error("term index out of range");

  a_done_to_acc: assert property (@(posedge clk) disable iff (rst)
    (div_stat.done && (state == ST_DIV)) |=> (state == ST_ACC))
    else $error("divider result not consumed");

endmodule

// File: dv/tb_ln1p_taylor_series_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ln1p_taylor_series_top
// Self-checking bench for the ln(1+x) series evaluator. A directed table
// covers the argument and epsilon extremes, clamping, the iteration limit
// and the zero cases; random arguments follow under several epsilon values.
// Every result transaction is compared against its typed table value or an in-bench series model.
// ----------------------------------------------------------------------------
module tb_ln1p_taylor_series_top;

  localparam int FRAC     = ln1p_pkg::FRAC_BITS_DEF;
  localparam int TERM_MAX = ln1p_pkg::MAX_TERMS_DEF;
  localparam int X_W      = FRAC + 2;
  localparam int SUM_W    = FRAC + 5;
  localparam int STALL_LIMIT = 400000;
  localparam int N_DIR    = 20;
  localparam int N_PHASE  = 4;
  localparam int PHASE_ITEMS = 20;

  typedef struct packed {
    logic signed [SUM_W-1:0]         log_sum;
    logic [ln1p_pkg::COUNT_W-1:0]    term_count;
    logic                            limit_hit;
  } log_result_t;

  typedef struct packed {
    logic [ln1p_pkg::EPS_W-1:0]  eps;
    logic signed [X_W-1:0]       x;
    logic                        typed;
    log_result_t                 want;
  } arg_row_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [ln1p_pkg::EPS_W-1:0] wr_data;

  ln1p_in_if  #(.FRAC_BITS(FRAC)) arg_if ();
  ln1p_out_if #(.FRAC_BITS(FRAC)) res_if ();

  ln1p_taylor_series_top #(
    .MAX_TERMS(TERM_MAX),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .arg    (arg_if),
    .res    (res_if),
    .wr_en  (wr_en),
    .wr_data(wr_data)
  );

  log_result_t                pending_logs[$];
  logic [ln1p_pkg::EPS_W-1:0] eps_shadow;
  int                         mismatch_cnt;
  int                         quiet_cycles;
  int                         stall_left;
  bit                         idle_on;

  // typed rows: results that follow directly from the series definition
  arg_row_t dir_tab [N_DIR] = '{
    '{16'd66,    18'sd0,       1'b1, '{21'sd0, 13'd1, 1'b0}},
    '{16'd66,    18'sd65536,   1'b0, '0},
    '{16'd66,   -18'sd65535,   1'b0, '0},
    '{16'd66,    18'sd1,       1'b0, '0},
    '{16'd66,   -18'sd1,       1'b0, '0},
    '{16'd66,    18'sh1FFFF,   1'b0, '0},   // above +1, clamps
    '{16'd66,    18'sh20000,   1'b0, '0},   // most negative code, clamps
    '{16'd66,   -18'sd65536,   1'b0, '0},   // exactly -1, clamps
    '{16'd66,    18'sd32768,   1'b0, '0},
    '{16'd66,   -18'sd32768,   1'b0, '0},
    '{16'hFFFF,  18'sd65536,   1'b1, '{21'sd32768, 13'd2, 1'b0}},
    '{16'hFFFF, -18'sd65535,   1'b1, '{-21'sd65535, 13'd1, 1'b0}},
    '{16'hFFFF,  18'sd65535,   1'b1, '{21'sd65535, 13'd1, 1'b0}},
    '{16'hFFFF,  18'sd0,       1'b1, '{21'sd0, 13'd1, 1'b0}},
    '{16'd1,     18'sd65536,   1'b0, '0},   // runs into the term limit
    '{16'd1,     18'sd16384,   1'b0, '0},
    '{16'd1,    -18'sd49152,   1'b0, '0},
    '{16'd0,     18'sd256,     1'b0, '0},   // stops once a term truncates to zero
    '{16'd0,    -18'sd65535,   1'b0, '0},
    '{16'd0,     18'sd0,       1'b1, '{21'sd0, 13'd1, 1'b0}}
  };

  // alternating series on magnitudes, saturated to Q4.F
  function automatic log_result_t ln1p_series(input logic [X_W-1:0] raw,
                                              input logic [ln1p_pkg::EPS_W-1:0] eps);
    longint      one, x, ax, pw, term, k, sum, thr, hi, lo;
    bit          neg, lim, stop;
    log_result_t r;
    one = longint'(1) << FRAC;
    x   = longint'($signed(raw));
    if (x < -(one - 1)) x = -(one - 1);
    if (x > one) x = one;
    neg = (x < 0);
    ax  = neg ? -x : x;
    if (FRAC >= 16) thr = longint'(eps) << (FRAC - 16);
    else thr = longint'(eps) >> (16 - FRAC);
    pw   = ax;
    k    = 1;
    sum  = 0;
    lim  = 1'b0;
    stop = 1'b0;
    while (!stop) begin
      term = pw / k;
      if (neg || (k % 2 == 0)) sum = sum - term;
      else sum = sum + term;
      if (term <= thr) begin
        stop = 1'b1;
      end else if (k >= TERM_MAX) begin
        lim  = 1'b1;
        stop = 1'b1;
      end else begin
        pw = (pw * ax + (longint'(1) << (FRAC - 1))) >> FRAC;
        k  = k + 1;
      end
    end
    hi = (longint'(1) << (FRAC + 4)) - 1;
    lo = -(longint'(1) << (FRAC + 4));
    if (sum > hi) sum = hi;
    if (sum < lo) sum = lo;
    r.log_sum    = sum[SUM_W-1:0];
    r.term_count = k[ln1p_pkg::COUNT_W-1:0];
    r.limit_hit  = lim;
    return r;
  endfunction

  // mostly moderate |x|; near-1 arguments only when epsilon keeps them short
  function automatic logic [X_W-1:0] pick_arg(input logic [ln1p_pkg::EPS_W-1:0] eps);
    int              sel, mag;
    logic [X_W-1:0]  r;
    sel = $urandom_range(0, 19);
    if (sel == 0 && eps >= 32) begin
      r = X_W'($urandom);
    end else if (sel <= 2 && eps >= 32) begin
      case ($urandom_range(0, 5))
        0: r = 18'sd0;
        1: r = 18'sd1;
        2: r = -18'sd1;
        3: r = 18'sd65536;
        4: r = -18'sd65535;
        default: r = 18'sd65535;
      endcase
    end else begin
      mag = $urandom_range(0, 58982);
      r = X_W'($urandom_range(0, 1) ? -mag : mag);
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_arg(input logic [X_W-1:0] x, input log_result_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      arg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    arg_if.valid   <= 1'b1;
    arg_if.x_value <= x;
    do @(posedge clk); while (!arg_if.ready);
    pending_logs.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    arg_if.valid <= 1'b0;
    while (pending_logs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_epsilon(input logic [ln1p_pkg::EPS_W-1:0] v);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    eps_shadow = v;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // result side back-pressure, random bursts with ready low
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 4);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    log_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_logs.size() == 0) begin
        $display("%0t: result with nothing pending: sum %0d count %0d limit %0b",
                 $time, res_if.log_sum, res_if.term_count, res_if.limit_hit);
        mismatch_cnt++;
      end else begin
        want = pending_logs.pop_front();
        if (res_if.log_sum !== want.log_sum) begin
          $display("%0t: log_sum expected %0d actual %0d", $time, want.log_sum,
                   res_if.log_sum);
          mismatch_cnt++;
        end
        if (res_if.term_count !== want.term_count) begin
          $display("%0t: term_count expected %0d actual %0d", $time,
                   want.term_count, res_if.term_count);
          mismatch_cnt++;
        end
        if (res_if.limit_hit !== want.limit_hit) begin
          $display("%0t: limit_hit expected %0b actual %0b", $time,
                   want.limit_hit, res_if.limit_hit);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (arg_if.valid && arg_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ln1p_taylor_series_top test failed");
        $finish;
      end
    end
  end

  initial begin
    log_result_t                want;
    logic [X_W-1:0]             x;
    logic [ln1p_pkg::EPS_W-1:0] phase_eps;
    rst            = 1'b1;
    wr_en          = 1'b0;
    wr_data        = '0;
    arg_if.valid   = 1'b0;
    arg_if.x_value = '0;
    res_if.ready   = 1'b0;
    stall_left     = 0;
    quiet_cycles   = 0;
    mismatch_cnt   = 0;
    idle_on        = 1'b1;
    eps_shadow     = ln1p_pkg::EPS_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].eps != eps_shadow) begin
        wait_idle();
        set_epsilon(dir_tab[i].eps);
      end
      want = dir_tab[i].typed ? dir_tab[i].want
                              : ln1p_series(dir_tab[i].x, eps_shadow);
      send_arg(dir_tab[i].x, want);
    end

    for (int p = 0; p < N_PHASE; p++) begin
      case (p)
        0: phase_eps = 16'hFFFF;
        1: phase_eps = 16'd1;
        2: phase_eps = ln1p_pkg::EPS_W'($urandom_range(2, 65534));
        default: phase_eps = ln1p_pkg::EPS_RESET;
      endcase
      wait_idle();
      set_epsilon(phase_eps);
      idle_on = (p != N_PHASE - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        x    = pick_arg(eps_shadow);
        want = ln1p_series(x, eps_shadow);
        send_arg(x, want);
      end
    end

    arg_if.valid <= 1'b0;
    while (pending_logs.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("ln1p_taylor_series_top test passed");
    end else begin
      $display("ln1p_taylor_series_top test failed");
    end
    $finish;
  end

endmodule
